/* design/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// shared types, sizes, codes and the glyph ramp of the fragment shader
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int MAX_LIGHTS   = 8;
    localparam int GLYPH_LEVELS = 12;

    // sizes derived from the light table depth and the glyph level count
    localparam int SLOTW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CNTW  = $clog2(MAX_LIGHTS + 1);
    localparam int TOTW  = 17 + $clog2(MAX_LIGHTS + 1);
    localparam int ACCW  = 19 + $clog2(MAX_LIGHTS + 1);
    localparam int GLW   = $clog2(GLYPH_LEVELS);

    // configuration port address width
    localparam int ADDR_W = 5;

    typedef logic signed [32:0] wide_t;   // difference of two s15.16 values
    typedef logic signed [17:0] nrm_t;    // normalised component, q1.16
    typedef logic signed [23:0] mop_t;    // multiplier operand
    typedef logic signed [47:0] prod_t;   // multiplier product
    typedef logic signed [39:0] dacc_t;   // dot product accumulator

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [47:0]        rgb;
        logic [31:0]        str;
    } light_t;

    typedef enum logic [1:0] {
        MODE_GLYPH       = 2'd0,
        MODE_GLYPH_COLOR = 2'd1,
        MODE_COLOR       = 2'd2,
        MODE_NORMAL      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_SHADE_MODE  = 3'd0,
        REG_LIGHT_COUNT = 3'd1,
        REG_CAMERA_X    = 3'd2,
        REG_CAMERA_Y    = 3'd3,
        REG_CAMERA_Z    = 3'd4
    } reg_idx_t;

    localparam logic OP_WRITE_LIGHT = 1'b0;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQUARE,
        N_ROOT,
        N_DIV,
        N_DONE
    } nstate_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_N_START,
        S_N_WAIT,
        S_V_START,
        S_V_WAIT,
        S_L_READ,
        S_L_START,
        S_L_WAIT,
        S_EDOT,
        S_REFL,
        S_PDOT,
        S_POW,
        S_SPEC,
        S_CHAN,
        S_OUT
    } state_t;

    // twelve-step brightness ramp, brightest first
    function automatic logic [6:0] ramp_char(input logic [3:0] idx);
        logic [6:0] ch;
        case (idx)
            4'd0:    ch = 7'h40;
            4'd1:    ch = 7'h24;
            4'd2:    ch = 7'h23;
            4'd3:    ch = 7'h2A;
            4'd4:    ch = 7'h21;
            4'd5:    ch = 7'h3D;
            4'd6:    ch = 7'h3B;
            4'd7:    ch = 7'h3A;
            4'd8:    ch = 7'h7E;
            4'd9:    ch = 7'h2D;
            4'd10:   ch = 7'h2C;
            4'd11:   ch = 7'h2E;
            default: ch = 7'h40;
        endcase
        return ch;
    endfunction

    localparam logic [6:0] GLYPH_AT = 7'h40;

endpackage

/* design/phong_fragment_shader.sv */
// ----------------------------------------------------------------------------
// phong_fragment_shader
// per-fragment phong shading over a small light table, with glyph ramp
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  s_*       s_valid/s_ready    operation, slot, position, normal, colour
//  m_*       m_valid/m_ready    glyph, out_red/green/blue
//  apb       psel/penable       shade_mode, light_count, camera_x/y/z
//
//  a light write is taken in the idle state; a fragment's shading is set by
//  the normaliser, run for the normal and view vectors and for each light
//  (32 root steps and 3x18 divide steps), and by the shared multiplier;
//  each normalisation adds a range shift, which a zero vector skips
//  reset clears the fsm, the output valid and the configuration registers to their defaults
//  a finished result waits in the output register; s_ready drops only while
//  a fragment is being shaded or its result cannot be stored
// ----------------------------------------------------------------------------
module phong_fragment_shader (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [2:0]                  s_light_slot,
    input  logic signed [31:0]          s_pos_x,
    input  logic signed [31:0]          s_pos_y,
    input  logic signed [31:0]          s_pos_z,
    input  logic signed [31:0]          s_normal_x,
    input  logic signed [31:0]          s_normal_y,
    input  logic signed [31:0]          s_normal_z,
    input  logic [15:0]                 s_color_red,
    input  logic [15:0]                 s_color_green,
    input  logic [15:0]                 s_color_blue,
    input  logic [31:0]                 s_light_strengths,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [6:0]                  m_glyph,
    output logic [15:0]                 m_out_red,
    output logic [15:0]                 m_out_green,
    output logic [15:0]                 m_out_blue,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pfs_pkg::*;

    localparam int NUMW = TOTW + 10;

    // configuration registers
    mode_t              shade_mode_reg;
    logic [3:0]         light_count_reg;
    logic signed [31:0] camera_reg [3];
    logic               cfg_we;

    // sequencer and datapath registers
    state_t             state_reg, state_next;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [31:0] nrm_reg [3];
    logic signed [31:0] nrm_next [3];
    logic [15:0]        fc_reg [3];
    logic [15:0]        fc_next [3];
    nrm_t               n_reg [3];
    nrm_t               n_next [3];
    nrm_t               v_reg [3];
    nrm_t               v_next [3];
    nrm_t               l_reg [3];
    nrm_t               l_next [3];
    logic signed [21:0] r_reg [3];
    logic signed [21:0] r_next [3];
    logic [ACCW-1:0]    acc_reg [3];
    logic [ACCW-1:0]    acc_next [3];
    dacc_t              dacc_reg, dacc_next;
    logic signed [23:0] e_reg, e_next;
    logic [16:0]        dif_reg, dif_next;
    logic [16:0]        p_reg, p_next;
    logic [16:0]        sp_reg, sp_next;
    logic [18:0]        term_reg, term_next;
    logic [TOTW-1:0]    total_reg, total_next;
    logic [CNTW-1:0]    i_reg, i_next;
    logic [CNTW-1:0]    count_reg, count_next;
    logic [1:0]         k_reg, k_next;
    logic [1:0]         j_reg, j_next;
    logic [2:0]         pw_reg, pw_next;

    // output register
    logic               ov_reg, ov_next;
    logic [6:0]         og_reg, og_next;
    logic [15:0]        oc_reg [3];
    logic [15:0]        oc_next [3];

    // light table and normaliser
    logic               mem_we;
    logic               mem_re;
    light_t             mem_wdata;
    light_t             mem_rdata;
    logic               norm_start;
    logic               norm_done;
    wide_t              norm_vin [3];
    nrm_t               norm_vout [3];
    logic signed [31:0] lpos [3];

    // shared multiplier
    mop_t               mul_a, mul_b;
    prod_t              prod;
    dacc_t              dsum;
    logic signed [23:0] dsum_q;
    logic [15:0]        lc;
    logic [CNTW-1:0]    count_lim;

    // glyph and output shaping
    logic signed [NUMW-1:0] gdiff, gnum, gshift;
    logic [GLW-1:0]         glevel;
    logic [3:0]             gidx;
    logic [6:0]             gchar;
    logic [18:0]            ndbg;
    logic [16:0]            nhalf [3];

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shade_mode_reg  <= MODE_GLYPH_COLOR;
            light_count_reg <= '0;
            camera_reg[0]   <= '0;
            camera_reg[1]   <= '0;
            camera_reg[2]   <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(paddr[4:2]))
                REG_SHADE_MODE:  shade_mode_reg  <= mode_t'(pwdata[1:0]);
                REG_LIGHT_COUNT: light_count_reg <= pwdata[3:0];
                REG_CAMERA_X:    camera_reg[0]   <= pwdata;
                REG_CAMERA_Y:    camera_reg[1]   <= pwdata;
                REG_CAMERA_Z:    camera_reg[2]   <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx_t'(paddr[4:2]))
            REG_SHADE_MODE:  prdata = {30'h0, shade_mode_reg};
            REG_LIGHT_COUNT: prdata = {28'h0, light_count_reg};
            REG_CAMERA_X:    prdata = camera_reg[0];
            REG_CAMERA_Y:    prdata = camera_reg[1];
            REG_CAMERA_Z:    prdata = camera_reg[2];
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // light table
    // ------------------------------------------------------------------
    assign s_ready   = (state_reg == S_IDLE);
    assign mem_we    = s_valid && s_ready && (s_operation == OP_WRITE_LIGHT)
                       && (int'(s_light_slot) < MAX_LIGHTS);
    assign mem_re    = (state_reg == S_L_READ);
    assign mem_wdata = '{px: s_pos_x, py: s_pos_y, pz: s_pos_z,
                         rgb: {s_color_blue, s_color_green, s_color_red},
                         str: s_light_strengths};

    pfs_light_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (SLOTW'(s_light_slot)),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (i_reg[SLOTW-1:0]),
        .rdata (mem_rdata)
    );

    assign lpos[0] = mem_rdata.px;
    assign lpos[1] = mem_rdata.py;
    assign lpos[2] = mem_rdata.pz;

    // ------------------------------------------------------------------
    // normaliser operand selection
    // ------------------------------------------------------------------
    assign norm_start = (state_reg == S_N_START) || (state_reg == S_V_START)
                        || (state_reg == S_L_START);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (state_reg)
                S_N_START: norm_vin[i] = wide_t'(nrm_reg[i]);
                S_V_START: norm_vin[i] = wide_t'(camera_reg[i]) - wide_t'(pos_reg[i]);
                default:   norm_vin[i] = wide_t'(lpos[i]) - wide_t'(pos_reg[i]);
            endcase
        end
    end

    pfs_normalize u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .vin     (norm_vin),
        .done    (norm_done),
        .vout    (norm_vout)
    );

    // ------------------------------------------------------------------
    // shared multiplier operands
    // ------------------------------------------------------------------
    always_comb begin
        case (k_reg)
            2'd0:    lc = mem_rdata.rgb[15:0];
            2'd1:    lc = mem_rdata.rgb[31:16];
            default: lc = mem_rdata.rgb[47:32];
        endcase
        case (state_reg)
            S_EDOT: begin
                mul_a = mop_t'(n_reg[k_reg]);
                mul_b = mop_t'(l_reg[k_reg]);
            end
            S_REFL: begin
                mul_a = e_reg;
                mul_b = mop_t'(n_reg[k_reg]);
            end
            S_PDOT: begin
                mul_a = mop_t'(v_reg[k_reg]);
                mul_b = mop_t'(r_reg[k_reg]);
            end
            S_POW: begin
                mul_a = mop_t'({7'h0, p_reg});
                mul_b = mop_t'({7'h0, p_reg});
            end
            S_SPEC: begin
                mul_a = mop_t'({8'h0, mem_rdata.str[31:16]});
                mul_b = mop_t'({7'h0, p_reg});
            end
            S_CHAN: begin
                case (j_reg)
                    2'd0: begin
                        mul_a = mop_t'({8'h0, lc});
                        mul_b = mop_t'({8'h0, mem_rdata.str[15:0]});
                    end
                    2'd1: begin
                        mul_a = mop_t'({8'h0, lc});
                        mul_b = mop_t'({7'h0, dif_reg});
                    end
                    2'd2: begin
                        mul_a = mop_t'({8'h0, lc});
                        mul_b = mop_t'({7'h0, sp_reg});
                    end
                    default: begin
                        mul_a = mop_t'({5'h0, term_reg});
                        mul_b = mop_t'({8'h0, fc_reg[k_reg]});
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign dsum   = dacc_reg + dacc_t'(prod);
    assign dsum_q = dsum[39:16];

    // ------------------------------------------------------------------
    // glyph level and normal debug colours
    // ------------------------------------------------------------------
    always_comb begin
        gdiff  = $signed(NUMW'(65536)) - $signed({{(NUMW - TOTW){1'b0}}, total_reg});
        gnum   = gdiff * $signed(NUMW'(GLYPH_LEVELS - 1));
        gshift = gnum >>> 16;
        if (gnum <= 0) begin
            glevel = '0;
        end else if (gshift > $signed(NUMW'(GLYPH_LEVELS - 1))) begin
            glevel = GLW'(GLYPH_LEVELS - 1);
        end else begin
            glevel = gshift[GLW-1:0];
        end
        // ramp position of each level, a constant table
        gidx = '0;
        for (int lv = 0; lv < GLYPH_LEVELS; lv++) begin
            if (int'(glevel) == lv) gidx = 4'((lv * 12) / GLYPH_LEVELS);
        end
        gchar = ramp_char(gidx);
        ndbg  = '0;
        for (int i = 0; i < 3; i++) begin
            ndbg     = 19'(n_reg[i]) + 19'h10000;
            nhalf[i] = ndbg[17:1];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        dacc_next  = dacc_reg;
        e_next     = e_reg;
        dif_next   = dif_reg;
        p_next     = p_reg;
        sp_next    = sp_reg;
        term_next  = term_reg;
        total_next = total_reg;
        i_next     = i_reg;
        count_next = count_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        pw_next    = pw_reg;
        ov_next    = ov_reg && !m_ready;
        og_next    = og_reg;
        for (int i = 0; i < 3; i++) begin
            pos_next[i] = pos_reg[i];
            nrm_next[i] = nrm_reg[i];
            fc_next[i]  = fc_reg[i];
            n_next[i]   = n_reg[i];
            v_next[i]   = v_reg[i];
            l_next[i]   = l_reg[i];
            r_next[i]   = r_reg[i];
            acc_next[i] = acc_reg[i];
            oc_next[i]  = oc_reg[i];
        end
        count_lim = (int'(light_count_reg) > MAX_LIGHTS) ? CNTW'(MAX_LIGHTS)
                                                         : CNTW'(light_count_reg);

        case (state_reg)
            // take a beat; light writes finish here
            S_IDLE: begin
                if (s_valid && s_operation != OP_WRITE_LIGHT) begin
                    pos_next[0] = s_pos_x;
                    pos_next[1] = s_pos_y;
                    pos_next[2] = s_pos_z;
                    nrm_next[0] = s_normal_x;
                    nrm_next[1] = s_normal_y;
                    nrm_next[2] = s_normal_z;
                    fc_next[0]  = s_color_red;
                    fc_next[1]  = s_color_green;
                    fc_next[2]  = s_color_blue;
                    for (int i = 0; i < 3; i++) acc_next[i] = '0;
                    total_next = '0;
                    i_next     = '0;
                    count_next = count_lim;
                    state_next = S_N_START;
                end
            end
            S_N_START: state_next = S_N_WAIT;
            S_N_WAIT: begin
                if (norm_done) begin
                    for (int i = 0; i < 3; i++) n_next[i] = norm_vout[i];
                    state_next = S_V_START;
                end
            end
            S_V_START: state_next = S_V_WAIT;
            S_V_WAIT: begin
                if (norm_done) begin
                    for (int i = 0; i < 3; i++) v_next[i] = norm_vout[i];
                    state_next = (count_reg == '0) ? S_OUT : S_L_READ;
                end
            end
            S_L_READ:  state_next = S_L_START;
            S_L_START: state_next = S_L_WAIT;
            S_L_WAIT: begin
                if (norm_done) begin
                    for (int i = 0; i < 3; i++) l_next[i] = norm_vout[i];
                    dacc_next  = '0;
                    k_next     = 2'd0;
                    state_next = S_EDOT;
                end
            end
            // e = n . l, diffuse is e clamped to [0, 1]
            S_EDOT: begin
                dacc_next = dsum;
                if (k_reg == 2'd2) begin
                    e_next = dsum_q;
                    if (dsum_q < 0) begin
                        dif_next = '0;
                    end else if (dsum_q > 24'sd65536) begin
                        dif_next = 17'd65536;
                    end else begin
                        dif_next = dsum_q[16:0];
                    end
                    k_next     = 2'd0;
                    state_next = S_REFL;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            // r = -l + 2 e n
            S_REFL: begin
                total_next = total_reg + TOTW'(dif_reg);
                r_next[k_reg] = prod[36:15] - 22'(l_reg[k_reg]);
                if (k_reg == 2'd2) begin
                    dacc_next  = '0;
                    k_next     = 2'd0;
                    state_next = S_PDOT;
                end else begin
                    total_next = total_reg;
                    k_next     = k_reg + 2'd1;
                end
            end
            // p = v . r clamped
            S_PDOT: begin
                dacc_next = dsum;
                if (k_reg == 2'd2) begin
                    if (dsum_q < 0) begin
                        p_next = '0;
                    end else if (dsum_q > 24'sd65536) begin
                        p_next = 17'd65536;
                    end else begin
                        p_next = dsum_q[16:0];
                    end
                    pw_next    = '0;
                    state_next = S_POW;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            // exponent 32 by five squarings
            S_POW: begin
                p_next = prod[32:16];
                if (pw_reg == 3'd4) begin
                    state_next = S_SPEC;
                end else begin
                    pw_next = pw_reg + 3'd1;
                end
            end
            S_SPEC: begin
                sp_next    = prod[32:16];
                k_next     = 2'd0;
                j_next     = 2'd0;
                state_next = S_CHAN;
            end
            // per channel light term, then scaled by the fragment colour
            S_CHAN: begin
                case (j_reg)
                    2'd0:    term_next = 19'(prod[31:16]);
                    2'd1:    term_next = term_reg + 19'(prod[32:16]);
                    2'd2:    term_next = term_reg + 19'(prod[32:16]);
                    default: acc_next[k_reg] = acc_reg[k_reg] + ACCW'(prod[34:16]);
                endcase
                j_next = j_reg + 2'd1;
                if (j_reg == 2'd3) begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd2) begin
                        i_next     = i_reg + CNTW'(1);
                        state_next = (i_reg + CNTW'(1) == count_reg) ? S_OUT : S_L_READ;
                    end
                end
            end
            // load the output register once it is free
            S_OUT: begin
                if (!ov_reg || m_ready) begin
                    ov_next = 1'b1;
                    case (shade_mode_reg)
                        MODE_GLYPH: begin
                            og_next = gchar;
                            for (int i = 0; i < 3; i++) oc_next[i] = 16'hFFFF;
                        end
                        MODE_NORMAL: begin
                            og_next = GLYPH_AT;
                            for (int i = 0; i < 3; i++) begin
                                oc_next[i] = nhalf[i][16] ? 16'hFFFF : nhalf[i][15:0];
                            end
                        end
                        default: begin
                            og_next = (shade_mode_reg == MODE_COLOR) ? GLYPH_AT : gchar;
                            for (int i = 0; i < 3; i++) begin
                                oc_next[i] = (acc_reg[i] > ACCW'(16'hFFFF)) ? 16'hFFFF
                                                                           : acc_reg[i][15:0];
                            end
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dacc_reg  <= dacc_next;
        e_reg     <= e_next;
        dif_reg   <= dif_next;
        p_reg     <= p_next;
        sp_reg    <= sp_next;
        term_reg  <= term_next;
        total_reg <= total_next;
        i_reg     <= i_next;
        count_reg <= count_next;
        k_reg     <= k_next;
        j_reg     <= j_next;
        pw_reg    <= pw_next;
        og_reg    <= og_next;
        for (int i = 0; i < 3; i++) begin
            pos_reg[i] <= pos_next[i];
            nrm_reg[i] <= nrm_next[i];
            fc_reg[i]  <= fc_next[i];
            n_reg[i]   <= n_next[i];
            v_reg[i]   <= v_next[i];
            l_reg[i]   <= l_next[i];
            r_reg[i]   <= r_next[i];
            acc_reg[i] <= acc_next[i];
            oc_reg[i]  <= oc_next[i];
        end
    end

    assign m_valid     = ov_reg;
    assign m_glyph     = og_reg;
    assign m_out_red   = oc_reg[0];
    assign m_out_green = oc_reg[1];
    assign m_out_blue  = oc_reg[2];

endmodule

/* design/pfs_light_mem.sv */
// ----------------------------------------------------------------------------
// pfs_light_mem
// light table: one write port, one registered read port
// ----------------------------------------------------------------------------
module pfs_light_mem (
    input  logic                    aclk,
    input  logic                    we,
    input  logic [pfs_pkg::SLOTW-1:0] waddr,
    input  pfs_pkg::light_t         wdata,
    input  logic                    re,
    input  logic [pfs_pkg::SLOTW-1:0] raddr,
    output pfs_pkg::light_t         rdata
);
    import pfs_pkg::*;

    light_t mem [MAX_LIGHTS];
    light_t rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/pfs_normalize.sv */
// ----------------------------------------------------------------------------
// pfs_normalize
// multi-cycle vector normaliser: range shift, sum of squares, bitwise root,
// restoring divide per component
// ----------------------------------------------------------------------------
module pfs_normalize (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  pfs_pkg::wide_t vin  [3],
    output logic           done,
    output pfs_pkg::nrm_t  vout [3]
);
    import pfs_pkg::*;

    nstate_t     state_reg, state_next;
    logic        neg_reg  [3];
    logic        neg_next [3];
    logic [32:0] mag_reg  [3];
    logic [32:0] mag_next [3];
    logic [32:0] m_reg, m_next;
    logic [61:0] sum_reg, sum_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] bit_reg, bit_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  k_reg, k_next;
    logic [32:0] drem_reg, drem_next;
    logic [17:0] dsh_reg, dsh_next;
    logic [17:0] q_reg, q_next;
    nrm_t        out_reg  [3];
    nrm_t        out_next [3];

    logic [32:0] mag_in [3];
    logic [32:0] max_in;
    logic [59:0] sq;
    logic [63:0] trial;
    logic [32:0] dtry;
    logic [32:0] dlen;
    logic [17:0] qn;
    logic [16:0] qc;

    // magnitudes and their maximum at start
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_in[i] = vin[i][32] ? 33'(-vin[i]) : 33'(vin[i]);
        end
        max_in = mag_in[0];
        if (mag_in[1] > max_in) max_in = mag_in[1];
        if (mag_in[2] > max_in) max_in = mag_in[2];
    end

    // control and datapath
    always_comb begin
        state_next = state_reg;
        m_next     = m_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        drem_next  = drem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        for (int i = 0; i < 3; i++) begin
            neg_next[i] = neg_reg[i];
            mag_next[i] = mag_reg[i];
            out_next[i] = out_reg[i];
        end

        sq    = mag_reg[k_reg][29:0] * mag_reg[k_reg][29:0];
        trial = root_reg + bit_reg;
        dlen  = {1'b0, root_reg[31:0]};
        dtry  = {drem_reg[31:0], dsh_reg[17]};
        qn    = {q_reg[16:0], (dtry >= dlen)};
        qc    = (qn > 18'd65536) ? 17'd65536 : qn[16:0];

        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    for (int i = 0; i < 3; i++) begin
                        neg_next[i] = vin[i][32];
                        mag_next[i] = mag_in[i];
                        out_next[i] = '0;
                    end
                    m_next     = max_in;
                    sum_next   = '0;
                    state_next = (max_in == '0) ? N_DONE : N_SHIFT;
                end
            end
            // bring the largest magnitude into [2^29, 2^30)
            N_SHIFT: begin
                if (m_reg[32:30] != '0) begin
                    m_next = m_reg >> 1;
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 1;
                end else if (m_reg[29] == 1'b0) begin
                    m_next = m_reg << 1;
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] << 1;
                end else begin
                    k_next     = 2'd0;
                    state_next = N_SQUARE;
                end
            end
            // sum of squares, one component a cycle
            N_SQUARE: begin
                sum_next = sum_reg + 62'(sq);
                if (k_reg == 2'd2) begin
                    rem_next   = {2'b00, sum_reg + 62'(sq)};
                    root_next  = '0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    cnt_next   = 5'd31;
                    state_next = N_ROOT;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            // floor square root, two bits of the radicand a cycle
            N_ROOT: begin
                if (rem_reg >= trial) begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == '0) begin
                    k_next     = 2'd0;
                    drem_next  = {2'b00, mag_reg[0][32:2]};
                    dsh_next   = {mag_reg[0][1:0], 16'h0000};
                    q_next     = '0;
                    cnt_next   = 5'd17;
                    state_next = N_DIV;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            // restoring divide, one quotient bit a cycle
            N_DIV: begin
                drem_next = (dtry >= dlen) ? (dtry - dlen) : dtry;
                dsh_next  = dsh_reg << 1;
                q_next    = qn;
                if (cnt_reg == '0) begin
                    out_next[k_reg] = neg_reg[k_reg] ? -nrm_t'({1'b0, qc})
                                                     : nrm_t'({1'b0, qc});
                    if (k_reg == 2'd2) begin
                        state_next = N_DONE;
                    end else begin
                        k_next    = k_reg + 2'd1;
                        drem_next = {2'b00, mag_reg[k_reg + 2'd1][32:2]};
                        dsh_next  = {mag_reg[k_reg + 2'd1][1:0], 16'h0000};
                        q_next    = '0;
                        cnt_next  = 5'd17;
                    end
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            N_DONE: begin
                state_next = N_IDLE;
            end
            default: begin
                state_next = N_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        m_reg    <= m_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        drem_reg <= drem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        for (int i = 0; i < 3; i++) begin
            neg_reg[i] <= neg_next[i];
            mag_reg[i] <= mag_next[i];
            out_reg[i] <= out_next[i];
        end
    end

    assign done = (state_reg == N_DONE);
    assign vout = out_reg;

endmodule
